### hw/rtl/bpiir_pkg.sv
// bpiir_pkg: shared types, widths and coefficient table of the bandpass iir
// used by bpiir_if.sv and bandpass_iir_order8_filter.sv
package bpiir_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int SCALED_W     = 12;
    localparam int COEF_W       = 25;
    localparam int ACC_W        = 48;
    localparam int HIST_DEPTH   = 8;
    localparam int POS_W        = $clog2(HIST_DEPTH);
    localparam int NUM_TAPS     = 2 * HIST_DEPTH + 1;
    localparam int TAP_W        = $clog2(NUM_TAPS);
    localparam int FRAC_BITS_DEF = 18;
    localparam int OUT_SHIFT_DEF = 4;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SCALED_W-1:0] t_scaled;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [ACC_W-1:0]    t_acc;
    typedef logic [TAP_W-1:0]           t_tap;

    // tap 0: current input; odd taps: input history; even taps: output history
    function automatic t_coef tap_coef(input t_tap tap);
        t_coef c;
        unique case (tap)
            5'd0:    c = 25'sd109;
            5'd2:    c = 25'sd1793154;
            5'd3:    c = -25'sd436;
            5'd4:    c = -25'sd5449517;
            5'd6:    c = 25'sd9608653;
            5'd7:    c = 25'sd655;
            5'd8:    c = -25'sd10750119;
            5'd10:   c = 25'sd7814738;
            5'd11:   c = -25'sd436;
            5'd12:   c = -25'sd3605114;
            5'd14:   c = 25'sd965224;
            5'd15:   c = 25'sd109;
            5'd16:   c = -25'sd114888;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

### hw/rtl/bpiir_if.sv
// bpiir_if: valid/ready channel interfaces for samples and filter results
// depends on bpiir_pkg
interface bpiir_in_if;
    logic               valid;
    logic               ready;
    bpiir_pkg::t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface bpiir_out_if;
    logic               valid;
    logic               ready;
    bpiir_pkg::t_sample filtered;
    bpiir_pkg::t_scaled scaled_out;

    modport source (output valid, output filtered, output scaled_out, input ready);
    modport sink   (input valid, input filtered, input scaled_out, output ready);
endinterface

### hw/rtl/bandpass_iir_order8_filter.sv
// bandpass_iir_order8_filter: eighth-order direct-form-i bandpass iir, one
// shared multiply-accumulate stepped over 17 taps; depends on bpiir_pkg, bpiir_if
// after a sample transaction the taps are stepped in ST_MAC, then ST_DRAIN and ST_DIV register the result
// no new sample is taken until ST_DIV issues the result, as all taps share the single multiplier and adder
// the result register frees the input side while a result waits to be taken
// reset (synchronous, active low) clears both histories, the ring position and valids
module bandpass_iir_order8_filter #(
    parameter int FRAC_BITS = bpiir_pkg::FRAC_BITS_DEF,
    parameter int OUT_SHIFT = bpiir_pkg::OUT_SHIFT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bpiir_in_if.sink      i_sample_ch,
    bpiir_out_if.source   o_result_ch
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MAC   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DIV   = 2'd3;

    localparam int                PROD_W   = bpiir_pkg::COEF_W + bpiir_pkg::SAMPLE_W;
    localparam bpiir_pkg::t_tap   LAST_TAP = bpiir_pkg::t_tap'(bpiir_pkg::NUM_TAPS - 1);
    localparam bpiir_pkg::t_acc   RND_BIAS =
        {{(bpiir_pkg::ACC_W - FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

    logic [1:0]                     r_state;
    bpiir_pkg::t_tap                r_tap;
    logic [bpiir_pkg::POS_W-1:0]    r_pos;
    bpiir_pkg::t_sample             r_xn;
    bpiir_pkg::t_sample             r_in_hist  [bpiir_pkg::HIST_DEPTH];
    bpiir_pkg::t_sample             r_out_hist [bpiir_pkg::HIST_DEPTH];
    logic signed [PROD_W-1:0]       r_prod;
    logic                           r_prod_vld;
    bpiir_pkg::t_acc                r_acc;
    logic                           r_out_valid;
    bpiir_pkg::t_sample             r_y;

    logic                           w_in_acc;
    logic                           w_out_free;
    logic [bpiir_pkg::POS_W:0]      w_lag;
    logic [bpiir_pkg::POS_W-1:0]    w_slot;
    bpiir_pkg::t_sample             w_data;
    bpiir_pkg::t_acc                w_biased;
    bpiir_pkg::t_acc                w_quot;
    bpiir_pkg::t_sample             w_y_next;
    bpiir_pkg::t_sample             w_y_shift;

    assign w_in_acc   = i_sample_ch.valid && i_sample_ch.ready;
    assign w_out_free = !r_out_valid || o_result_ch.ready;

    assign i_sample_ch.ready = (r_state == ST_IDLE);

    // lag of the history tap: odd taps (k+1)/2, even taps k/2
    assign w_lag  = (bpiir_pkg::POS_W + 1)'(r_tap[bpiir_pkg::TAP_W-1:1])
                  + (bpiir_pkg::POS_W + 1)'(r_tap[0]);
    assign w_slot = r_pos - w_lag[bpiir_pkg::POS_W-1:0];

    always_comb begin
        if (r_tap == '0) begin
            w_data = r_xn;
        end else if (r_tap[0]) begin
            w_data = r_in_hist[w_slot];
        end else begin
            w_data = r_out_hist[w_slot];
        end
    end

    // truncate toward zero
    assign w_biased  = r_acc[bpiir_pkg::ACC_W-1] ? (r_acc + RND_BIAS) : r_acc;
    assign w_quot    = w_biased >>> FRAC_BITS;
    assign w_y_next  = w_quot[bpiir_pkg::SAMPLE_W-1:0];
    assign w_y_shift = r_y >>> OUT_SHIFT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tap       <= '0;
            r_pos       <= '0;
            r_prod_vld  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < bpiir_pkg::HIST_DEPTH; i++) begin
                r_in_hist[i]  <= '0;
                r_out_hist[i] <= '0;
            end
        end else begin
            if (r_state == ST_DIV && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result_ch.ready) begin
                r_out_valid <= 1'b0;
            end
            r_prod_vld <= (r_state == ST_MAC);
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= ST_MAC;
                        r_tap   <= '0;
                    end
                end
                ST_MAC: begin
                    r_tap <= r_tap + 1'b1;
                    if (r_tap == LAST_TAP) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (w_out_free) begin
                        r_in_hist[r_pos]  <= r_xn;
                        r_out_hist[r_pos] <= w_y_next;
                        r_pos             <= r_pos + 1'b1;
                        r_state           <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_xn  <= i_sample_ch.sample;
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + bpiir_pkg::ACC_W'(r_prod);
        end
        r_prod <= bpiir_pkg::tap_coef(r_tap) * w_data;
        if (r_state == ST_DIV && w_out_free) begin
            r_y <= w_y_next;
        end
    end

    assign o_result_ch.valid      = r_out_valid;
    assign o_result_ch.filtered   = r_y;
    assign o_result_ch.scaled_out = w_y_shift[bpiir_pkg::SCALED_W-1:0];

    a_accept_starts_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == ST_MAC) && (r_tap == '0))
        else $error("sample transaction did not start the tap sequence");

    a_last_tap_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAC) && (r_tap == LAST_TAP) |=> (r_state == ST_DRAIN) && r_prod_vld)
        else $error("tap sequence did not end in drain");

    a_result_advances_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) && w_out_free
            |=> r_out_valid && (r_pos == $past(r_pos) + 1'b1) && (r_state == ST_IDLE))
        else $error("result issue did not advance the ring position");

    a_no_accept_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !i_sample_ch.ready)
        else $error("input ready while a sample is in progress");

endmodule

### tb/bandpass_iir_order8_filter_tb.sv
`timescale 1ns / 100ps
// bandpass_iir_order8_filter_tb: self-checking testbench for the eighth-order bandpass iir
// a scoreboard class predicts every result; plain tasks drive both channels
// depends on bpiir_pkg, bpiir_if and bandpass_iir_order8_filter

typedef struct packed {
    bpiir_pkg::t_sample filtered;
    bpiir_pkg::t_scaled scaled_out;
} t_filter_result;

class bpiir_scoreboard;
    longint         x_coef [9] = '{109, 0, -436, 0, 655, 0, -436, 0, 109};
    longint         y_coef [8] = '{1793154, -5449517, 9608653, -10750119,
                                   7814738, -3605114, 965224, -114888};
    bpiir_pkg::t_sample          x_hist [bpiir_pkg::HIST_DEPTH];
    bpiir_pkg::t_sample          y_hist [bpiir_pkg::HIST_DEPTH];
    logic [bpiir_pkg::POS_W-1:0] ring_pos;
    t_filter_result              expected_q [$];
    int unsigned                 fail_count;

    function new();
        for (int i = 0; i < bpiir_pkg::HIST_DEPTH; i++) begin
            x_hist[i] = '0;
            y_hist[i] = '0;
        end
        ring_pos   = '0;
        fail_count = 0;
    endfunction

    // one accepted sample transaction: run the filter and queue its result
    function void note_sample(bpiir_pkg::t_sample x);
        longint                      acc;
        longint                      quot;
        logic [bpiir_pkg::POS_W-1:0] slot;
        bpiir_pkg::t_sample          y;
        bpiir_pkg::t_sample          shifted;
        t_filter_result              r;
        acc = x_coef[0] * longint'(x);
        for (int lag = 1; lag <= bpiir_pkg::HIST_DEPTH; lag++) begin
            slot = ring_pos - (bpiir_pkg::POS_W)'(lag);
            acc += x_coef[lag] * longint'(x_hist[slot]);
            acc += y_coef[lag-1] * longint'(y_hist[slot]);
        end
        quot = acc / (longint'(1) << bpiir_pkg::FRAC_BITS_DEF);
        y = quot[bpiir_pkg::SAMPLE_W-1:0];
        x_hist[ring_pos] = x;
        y_hist[ring_pos] = y;
        ring_pos = ring_pos + 1'b1;
        shifted = y >>> bpiir_pkg::OUT_SHIFT_DEF;
        r.filtered   = y;
        r.scaled_out = shifted[bpiir_pkg::SCALED_W-1:0];
        expected_q.push_back(r);
    endfunction

    // one accepted result transaction against the oldest prediction
    function void check_result(bpiir_pkg::t_sample filtered, bpiir_pkg::t_scaled scaled_out);
        t_filter_result e;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result filtered=%0d scaled_out=%0d",
                     $time, filtered, scaled_out);
            fail_count++;
            return;
        end
        e = expected_q.pop_front();
        if (filtered !== e.filtered) begin
            $display("%0t: filtered mismatch expected=%0d actual=%0d",
                     $time, e.filtered, filtered);
            fail_count++;
        end
        if (scaled_out !== e.scaled_out) begin
            $display("%0t: scaled_out mismatch expected=%0d actual=%0d",
                     $time, e.scaled_out, scaled_out);
            fail_count++;
        end
    endfunction
endclass

module bandpass_iir_order8_filter_tb;

    localparam int RANDOM_ITEMS  = 780;
    localparam int HOLD_AT       = 250;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 60;

    logic i_clk;
    logic i_rst_n;

    bpiir_in_if  sample_ch ();
    bpiir_out_if result_ch ();

    bpiir_scoreboard sb;
    int unsigned     results_taken;

    bandpass_iir_order8_filter #(
        .FRAC_BITS (bpiir_pkg::FRAC_BITS_DEF),
        .OUT_SHIFT (bpiir_pkg::OUT_SHIFT_DEF)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_ch (sample_ch),
        .o_result_ch (result_ch)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        sb = new();
        results_taken    = 0;
        i_rst_n          = 1'b0;
        sample_ch.valid  = 1'b0;
        sample_ch.sample = '0;
        result_ch.ready  = 1'b0;
    end

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_sample(input bpiir_pkg::t_sample x, input int gap);
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= x;
        do @(posedge i_clk); while (!sample_ch.ready);
        sb.note_sample(x);
        @(negedge i_clk);
    endtask

    task automatic take_result(input int idle);
        if (idle > 0) begin
            result_ch.ready <= 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        result_ch.ready <= 1'b1;
        do @(posedge i_clk); while (!result_ch.valid);
        sb.check_result(result_ch.filtered, result_ch.scaled_out);
        results_taken++;
        @(negedge i_clk);
    endtask

    function automatic int draw_gap(input int idx);
        if (((idx / 64) % 4) == 3)
            return 0;
        return $urandom_range(0, 5);
    endfunction

    // receiver, with one long hold-off so the input side backs up
    initial begin
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (results_taken == HOLD_AT) begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            take_result(draw_gap(results_taken));
        end
    end

    initial begin
        bpiir_pkg::t_sample directed [24];
        int                 idx;
        int                 mode;
        int                 run_left;
        int                 period;
        int                 amp;
        int                 phase;
        bpiir_pkg::t_sample x;

        directed = '{
            16'sh7fff, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh8000, 16'sh0000,
            16'shffff, 16'sh0001, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000,
            16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
            16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh5555, 16'shaaaa
        };

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        idx = 0;
        foreach (directed[i]) begin
            send_sample(directed[i], draw_gap(idx));
            idx++;
        end

        run_left = 0;
        mode     = 0;
        period   = 4;
        amp      = 0;
        phase    = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (run_left == 0) begin
                mode     = $urandom_range(0, 4);
                run_left = $urandom_range(16, 48);
                period   = 2 * $urandom_range(1, 12);
                amp      = $urandom_range(0, 32767);
                phase    = 0;
            end
            case (mode)
                0: x = bpiir_pkg::t_sample'($urandom);
                1: begin
                    case ($urandom_range(0, 3))
                        0: x = 16'sh7fff;
                        1: x = 16'sh8000;
                        2: x = 16'sh0000;
                        default: x = 16'shffff;
                    endcase
                end
                2: x = bpiir_pkg::t_sample'($signed($urandom_range(0, 128)) - 64);
                3: x = (phase < period / 2) ? bpiir_pkg::t_sample'(amp)
                                            : bpiir_pkg::t_sample'(-amp - 1);
                default: x = (phase == 0) ? bpiir_pkg::t_sample'($urandom) : 16'sh0000;
            endcase
            phase = (phase + 1) % period;
            run_left--;
            send_sample(x, draw_gap(idx));
            idx++;
        end
        sample_ch.valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.expected_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, sb.expected_q.size());
            sb.fail_count++;
        end
        if (sb.fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
